// ----- hw/rtl/plfr_pkg.sv -----
`default_nettype none
package plfr_pkg;

  localparam int unsigned SQ_CELLS = 25;
  localparam int unsigned LETTERS  = 26;

  localparam logic [4:0] LET_I = 5'd8;
  localparam logic [4:0] LET_J = 5'd9;
  localparam logic [4:0] LET_X = 5'd23;

  localparam logic [6:0] ASCII_A = 7'd65;

  typedef logic [LETTERS-1:0] lmask_t;
  localparam lmask_t J_MASK = lmask_t'(1) << LET_J;

  typedef enum logic [1:0] {
    FN_KEY    = 2'd0,
    FN_FINISH = 2'd1,
    FN_MSG    = 2'd2,
    FN_END    = 2'd3
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic [6:0] cipher_char;
    logic       pair_last;
    logic       message_end;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD_A,
    ST_RD_B,
    ST_RD_CA,
    ST_RD_CB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } clean_t;

  // letter index 0..25, J folded to I
  function automatic clean_t clean_letter(input logic [7:0] code);
    clean_t     res;
    logic [7:0] d;
    res = '0;
    d   = '0;
    if (code >= 8'd65 && code <= 8'd90) begin
      d      = code - 8'd65;
      res.ok = 1'b1;
    end else if (code >= 8'd97 && code <= 8'd122) begin
      d      = code - 8'd97;
      res.ok = 1'b1;
    end
    res.idx = d[4:0];
    if (res.idx == LET_J) begin
      res.idx = LET_I;
    end
    return res;
  endfunction

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    r = 3'd0;
    priority if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15)     r = 3'd3;
    else if (p >= 5'd10)     r = 3'd2;
    else if (p >= 5'd5)      r = 3'd1;
    else                     r = 3'd0;
    return r;
  endfunction

  function automatic logic [4:0] mk_pos(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] c;
    c = p - mk_pos(pos_row(p), 3'd0);
    return c[2:0];
  endfunction

  function automatic logic [2:0] inc5(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/plfr_ram.sv -----
`default_nettype none
module plfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/playfair_cipher_encryptor_unit.sv -----
`default_nettype none
// Playfair encryptor over ASCII bytes. Key bytes (func 0) fill a 5x5 square; a finish
// request (func 1) completes it with the unused letters, one letter per cycle.
// Message bytes (func 2) and end of message (func 3) before finish are dropped; a key
// byte after finish starts a new key. Key bytes and message bytes that only buffer a
// letter stay in the idle state. For a request that closes a pair, the letter-place
// memory and then the key-square memory each have one read port, so the two positions
// and the two cipher letters are read one after another. The two cipher letters then
// leave from a two-entry output buffer; a new request is taken while they wait.
module playfair_cipher_encryptor_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plfr_pkg::in_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output plfr_pkg::out_req_t     out_req
);
  import plfr_pkg::*;

  state_e     state_r, state_nxt;
  lmask_t     used_r, used_nxt;
  logic [4:0] fill_r, fill_nxt;
  logic       fin_r, fin_nxt;
  logic [4:0] pend_r, pend_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic [4:0] a_r, a_nxt;
  logic [4:0] b_r, b_nxt;
  logic       flag_r, flag_nxt;
  logic [4:0] pa_r, pa_nxt;
  logic [4:0] ob_r, ob_nxt;
  logic [4:0] t0_r, t0_nxt;
  logic [4:0] o0_r, o0_nxt;
  logic [4:0] o1_r, o1_nxt;
  logic       oend_r, oend_nxt;

  logic       place_en;
  logic [4:0] place_let;
  logic [4:0] place_fill;
  logic       lp_re, ks_re;
  logic [4:0] lp_raddr, ks_raddr;
  logic [4:0] lp_rdata, ks_rdata;

  clean_t     cl;
  lmask_t     used_base;
  logic [4:0] fill_base;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] oa, ob;

  plfr_ram #(.WIDTH(5), .DEPTH(LETTERS)) u_place (
    .clk   (clk),
    .we    (place_en),
    .waddr (place_let),
    .wdata (place_fill),
    .re    (lp_re),
    .raddr (lp_raddr),
    .rdata (lp_rdata)
  );

  plfr_ram #(.WIDTH(5), .DEPTH(SQ_CELLS)) u_square (
    .clk   (clk),
    .we    (place_en),
    .waddr (place_fill),
    .wdata (place_let),
    .re    (ks_re),
    .raddr (ks_raddr),
    .rdata (ks_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= J_MASK;
      fill_r     <= '0;
      fin_r      <= 1'b0;
      pend_r     <= '0;
      pend_vld_r <= 1'b0;
      idx_r      <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      fill_r     <= fill_nxt;
      fin_r      <= fin_nxt;
      pend_r     <= pend_nxt;
      pend_vld_r <= pend_vld_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    flag_r <= flag_nxt;
    pa_r   <= pa_nxt;
    ob_r   <= ob_nxt;
    t0_r   <= t0_nxt;
    o0_r   <= o0_nxt;
    o1_r   <= o1_nxt;
    oend_r <= oend_nxt;
  end

  always_comb begin
    ra = pos_row(pa_r);
    ca = pos_col(pa_r);
    rb = pos_row(lp_rdata);
    cb = pos_col(lp_rdata);
    if (ra == rb) begin
      oa = mk_pos(ra, inc5(ca));
      ob = mk_pos(rb, inc5(cb));
    end else if (ca == cb) begin
      oa = mk_pos(inc5(ra), ca);
      ob = mk_pos(inc5(rb), cb);
    end else begin
      oa = mk_pos(ra, cb);
      ob = mk_pos(rb, ca);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    fill_nxt     = fill_r;
    fin_nxt      = fin_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    flag_nxt     = flag_r;
    pa_nxt       = pa_r;
    ob_nxt       = ob_r;
    t0_nxt       = t0_r;
    o0_nxt       = o0_r;
    o1_nxt       = o1_r;
    oend_nxt     = oend_r;

    place_en   = 1'b0;
    place_let  = '0;
    place_fill = '0;
    lp_re      = 1'b0;
    lp_raddr   = a_r;
    ks_re      = 1'b0;
    ks_raddr   = ob_r;

    cl        = clean_letter(in_req.char_code);
    used_base = fin_r ? J_MASK : used_r;
    fill_base = fin_r ? 5'd0 : fill_r;

    in_ready  = (state_r == ST_IDLE);
    out_valid = (cnt_r != 2'd0);
    if (cnt_r == 2'd2) begin
      out_req = '{cipher_char: ASCII_A + {2'b00, o0_r}, pair_last: 1'b0, message_end: 1'b0};
    end else begin
      out_req = '{cipher_char: ASCII_A + {2'b00, o1_r}, pair_last: 1'b1, message_end: oend_r};
    end
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_r - 2'd1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_req.func)
            FN_KEY: begin
              fin_nxt      = 1'b0;
              used_nxt     = used_base;
              fill_nxt     = fill_base;
              if (fin_r) begin
                pend_vld_nxt = 1'b0;
              end
              place_let  = cl.idx;
              place_fill = fill_base;
              if (cl.ok && !used_base[cl.idx] && fill_base < 5'(SQ_CELLS)) begin
                place_en = 1'b1;
                used_nxt = used_base | (lmask_t'(1) << cl.idx);
                fill_nxt = fill_base + 5'd1;
              end
            end
            FN_FINISH: begin
              if (!fin_r) begin
                idx_nxt   = '0;
                state_nxt = ST_FILL;
              end
            end
            FN_MSG: begin
              if (fin_r && cl.ok) begin
                if (!pend_vld_r) begin
                  pend_nxt     = cl.idx;
                  pend_vld_nxt = 1'b1;
                end else begin
                  a_nxt     = pend_r;
                  flag_nxt  = 1'b0;
                  state_nxt = ST_RD_A;
                  if (pend_r == cl.idx) begin
                    b_nxt = LET_X;
                  end else begin
                    b_nxt        = cl.idx;
                    pend_vld_nxt = 1'b0;
                  end
                end
              end
            end
            FN_END: begin
              if (fin_r && pend_vld_r) begin
                a_nxt        = pend_r;
                b_nxt        = LET_X;
                flag_nxt     = 1'b1;
                pend_vld_nxt = 1'b0;
                state_nxt    = ST_RD_A;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        place_let  = idx_r;
        place_fill = fill_r;
        if (!used_r[idx_r] && fill_r < 5'(SQ_CELLS)) begin
          place_en = 1'b1;
          used_nxt = used_r | (lmask_t'(1) << idx_r);
          fill_nxt = fill_r + 5'd1;
        end
        idx_nxt = idx_r + 5'd1;
        if (idx_r == 5'(LETTERS - 1)) begin
          fin_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_A: begin
        lp_re     = 1'b1;
        lp_raddr  = a_r;
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        lp_re     = 1'b1;
        lp_raddr  = b_r;
        pa_nxt    = lp_rdata;
        state_nxt = ST_RD_CA;
      end
      ST_RD_CA: begin
        ks_re     = 1'b1;
        ks_raddr  = oa;
        ob_nxt    = ob;
        state_nxt = ST_RD_CB;
      end
      ST_RD_CB: begin
        ks_re     = 1'b1;
        ks_raddr  = ob_r;
        t0_nxt    = ks_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (cnt_r == 2'd0) begin
          o0_nxt    = t0_r;
          o1_nxt    = ks_rdata;
          oend_nxt  = flag_r;
          cnt_nxt   = 2'd2;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/plfr_chk.sv -----
`default_nettype none
module plfr_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire plfr_pkg::in_req_t  in_req,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire plfr_pkg::out_req_t out_req
);
  import plfr_pkg::*;

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_req.cipher_char >= 7'd65 && out_req.cipher_char <= 7'd90 &&
                   out_req.cipher_char != 7'd74))
    else $error("cipher letter out of range");

  a_end_on_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_req.message_end) |-> out_req.pair_last)
    else $error("message end on first letter of pair");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_req.pair_last) |=> (out_valid && out_req.pair_last))
    else $error("second letter of pair missing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_req)))
    else $error("stalled result changed");

  a_key_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req.func == FN_KEY) |=> in_ready)
    else $error("key byte request held the input");

endmodule

bind playfair_cipher_encryptor_unit plfr_chk u_plfr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_req   (out_req)
);
`default_nettype wire

// ----- tb/tb_playfair_cipher_encryptor_unit.sv -----
`timescale 1ns / 100ps

module tb_playfair_cipher_encryptor_unit;
  import plfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 425;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  playfair_cipher_encryptor_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // key square as the encryptor should hold it
  logic [4:0]  sq_letter [SQ_CELLS];
  logic [4:0]  sq_cell   [LETTERS];
  lmask_t      sq_used     = J_MASK;
  int unsigned sq_fill     = 0;
  bit          sq_done     = 1'b0;
  logic [4:0]  held_letter = '0;
  bit          held_ok     = 1'b0;

  in_req_t     req_q    [$];
  out_req_t    cipher_q [$];
  out_req_t    want;

  int unsigned in_idle_pct  = 34;
  int unsigned out_idle_pct = 75;
  int unsigned counted      = 0;
  int unsigned cycles       = 0;
  int unsigned n_sent       = 0;
  int unsigned n_letters    = 0;
  int unsigned n_squares    = 0;
  int unsigned n_pads       = 0;
  int unsigned errors       = 0;

  function automatic bit to_letter(input logic [7:0] code, output logic [4:0] idx);
    bit ok;
    ok  = 1'b1;
    idx = '0;
    if (code >= "A" && code <= "Z") begin
      idx = 5'(code - "A");
    end else if (code >= "a" && code <= "z") begin
      idx = 5'(code - "a");
    end else begin
      ok = 1'b0;
    end
    if (idx == LET_J) begin
      idx = LET_I;
    end
    return ok;
  endfunction

  task automatic place_in_square(input logic [4:0] idx);
    if (sq_fill < SQ_CELLS && !sq_used[idx]) begin
      sq_used[idx]       = 1'b1;
      sq_letter[sq_fill] = idx;
      sq_cell[idx]       = 5'(sq_fill);
      sq_fill++;
    end
  endtask

  task automatic encipher_pair(input logic [4:0] a, input logic [4:0] b, input bit pad);
    int       ra, ca, rb, cb, oa, ob;
    out_req_t r;
    ra = sq_cell[a] / 5;
    ca = sq_cell[a] % 5;
    rb = sq_cell[b] / 5;
    cb = sq_cell[b] % 5;
    if (ra == rb) begin
      oa = ra * 5 + (ca + 1) % 5;
      ob = rb * 5 + (cb + 1) % 5;
    end else if (ca == cb) begin
      oa = ((ra + 1) % 5) * 5 + ca;
      ob = ((rb + 1) % 5) * 5 + cb;
    end else begin
      oa = ra * 5 + cb;
      ob = rb * 5 + ca;
    end
    r.cipher_char = ASCII_A + 7'(sq_letter[oa]);
    r.pair_last   = 1'b0;
    r.message_end = 1'b0;
    cipher_q.push_back(r);
    r.cipher_char = ASCII_A + 7'(sq_letter[ob]);
    r.pair_last   = 1'b1;
    r.message_end = pad;
    cipher_q.push_back(r);
    if (pad) begin
      n_pads++;
    end
  endtask

  task automatic encrypt_request(input in_req_t r);
    logic [4:0] idx;
    bit         ok;
    ok = to_letter(r.char_code, idx);
    case (r.func)
      FN_KEY: begin
        if (sq_done) begin
          sq_used = J_MASK;
          sq_fill = 0;
          sq_done = 1'b0;
          held_ok = 1'b0;
        end
        if (ok) begin
          place_in_square(idx);
        end
      end
      FN_FINISH: begin
        if (!sq_done) begin
          for (int i = 0; i < LETTERS; i++) begin
            place_in_square(5'(i));
          end
          sq_done = 1'b1;
          n_squares++;
        end
      end
      FN_MSG: begin
        if (sq_done && ok) begin
          n_letters++;
          if (!held_ok) begin
            held_letter = idx;
            held_ok     = 1'b1;
          end else if (held_letter == idx) begin
            encipher_pair(held_letter, LET_X, 1'b0);
          end else begin
            encipher_pair(held_letter, idx, 1'b0);
            held_ok = 1'b0;
          end
        end
      end
      FN_END: begin
        if (sq_done && held_ok) begin
          encipher_pair(held_letter, LET_X, 1'b1);
          held_ok = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d cipher letters still awaited", $time, cipher_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encrypt_request(in_req);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_req   <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // cipher letter monitor
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected cipher letter, actual char=%h last=%b end=%b", $time,
                 out_req.cipher_char, out_req.pair_last, out_req.message_end);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (want !== out_req) begin
          $display("%0t: mismatch, expected char=%h last=%b end=%b, actual char=%h last=%b end=%b",
                   $time, want.cipher_char, want.pair_last, want.message_end,
                   out_req.cipher_char, out_req.pair_last, out_req.message_end);
          errors++;
        end
      end
    end
  end

  task automatic push_req(input func_e f, input logic [7:0] code);
    in_req_t r;
    r.func      = f;
    r.char_code = code;
    req_q.push_back(r);
    counted++;
  endtask

  function automatic logic [7:0] rand_letter();
    logic [4:0] idx;
    idx = ($urandom_range(0, 9) == 0) ? LET_X : 5'($urandom_range(0, 25));
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(idx);
  endfunction

  task automatic random_session();
    int         n;
    logic [7:0] last;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        push_req(func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(26, 32) : $urandom_range(0, 10);
      repeat (n) begin
        push_req(FN_KEY, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                   : rand_letter());
      end
      push_req(FN_FINISH, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        push_req(FN_FINISH, 8'($urandom_range(0, 255)));
      end
      n    = $urandom_range(1, 24);
      last = rand_letter();
      repeat (n) begin
        if ($urandom_range(0, 99) < 8) begin
          push_req(FN_MSG, 8'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 99) >= 20) begin
            last = rand_letter();
          end
          push_req(FN_MSG, last);
        end
      end
      if ($urandom_range(0, 99) < 85) begin
        push_req(FN_END, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain();
    while (req_q.size() != 0 || in_valid || cipher_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // dropped before the square exists, then case folding, J as I, repeats, non-letters
    push_req(FN_MSG, "A");
    push_req(FN_END, 8'h00);
    push_req(FN_KEY, 8'hFF);
    push_req(FN_KEY, "z");
    push_req(FN_KEY, "J");
    push_req(FN_KEY, "i");
    push_req(FN_KEY, "Z");
    push_req(FN_KEY, 8'h40);
    push_req(FN_KEY, 8'h5B);
    push_req(FN_KEY, "X");
    push_req(FN_FINISH, 8'hFF);
    push_req(FN_FINISH, 8'h00);
    push_req(FN_MSG, "a");
    push_req(FN_MSG, 8'h80);
    push_req(FN_MSG, "A");
    push_req(FN_MSG, "z");
    push_req(FN_MSG, "x");
    push_req(FN_MSG, "X");
    push_req(FN_MSG, "j");
    push_req(FN_MSG, "x");
    push_req(FN_END, 8'hFF);
    push_req(FN_END, 8'h00);
    push_req(FN_MSG, "q");
    push_req(FN_KEY, "b");
    push_req(FN_FINISH, 8'h00);
    push_req(FN_MSG, "b");
    push_req(FN_END, 8'h00);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 34 : (ph == 1) ? 75 : 0;
      out_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 34 : 0;
      counted      = 0;
      while (counted < PHASE_ITEMS) begin
        random_session();
      end
      drain();
    end

    repeat (40) @(posedge clk);

    $display("Sent %0d requests: %0d key squares built, %0d message letters taken,",
             n_sent, n_squares, n_letters);
    $display("  %0d end-of-message pads; %0d mismatches", n_pads, errors);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- playfair_cipher_encryptor_unit.f -----
hw/rtl/plfr_pkg.sv
hw/rtl/plfr_ram.sv
hw/rtl/playfair_cipher_encryptor_unit.sv
hw/rtl/plfr_chk.sv
tb/tb_playfair_cipher_encryptor_unit.sv
